// File: rtl/core/rbe_pkg.sv
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared types, register indexes, reset values and helpers for the
// rigid body Euler step block.
// ----------------------------------------------------------------------------
package rbe_pkg;

  typedef enum logic [2:0] {
    REG_GRAVITY_X = 3'd0,
    REG_GRAVITY_Y = 3'd1,
    REG_FRICTION  = 3'd2,
    REG_BODY_MASS = 3'd3,
    REG_INV_MASS  = 3'd4
  } rbe_reg_e;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } rbe_op_e;

  typedef struct packed {
    logic    start;
    rbe_op_e op;
  } rbe_iter_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_AX, S_VX, S_AY, S_VY,
    S_GX2, S_GY2, S_GLEN, S_UX, S_UY, S_D1, S_D2, S_RX, S_RY,
    S_GVX, S_GVY,
    S_FCHK, S_F1, S_F2, S_V2X, S_V2Y, S_VLEN, S_DX1, S_DX2, S_DY1, S_DY2,
    S_PX, S_PY, S_DONE
  } rbe_state_e;

  localparam logic signed [31:0] GRAVITY_X_RST = 32'sd0;
  localparam logic signed [31:0] GRAVITY_Y_RST = 32'sd52428800;
  localparam logic [30:0]        FRICTION_RST  = 31'd6553600;
  localparam logic [30:0]        BODY_MASS_RST = 31'd65536;
  localparam logic [30:0]        INV_MASS_RST  = 31'd65536;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  function automatic logic signed [47:0] sx48(input logic signed [31:0] v);
    return {{16{v[31]}}, v};
  endfunction

endpackage

// File: rtl/core/rbe_iter.sv
// ----------------------------------------------------------------------------
// rbe_iter
// Shared iterative unit: 64-bit integer square root, one result bit per
// cycle, or 64 by 32 bit restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbe_iter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rbe_pkg::rbe_iter_req_t req_i,
  input  logic [63:0]           num_i,
  input  logic [31:0]           den_i,
  output logic                  done_o,
  output logic [31:0]           res_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [5:0]      cnt_q, cnt_d;
  rbe_pkg::rbe_op_e op_q;
  logic [63:0]     x_q, x_n;
  logic [34:0]     rem_q, rem_n;
  logic [31:0]     acc_q, acc_n;
  logic [31:0]     den_q;
  logic [34:0]     sq_rem, sq_trial, dv_rem, dv_den;

  assign sq_rem   = {rem_q[32:0], x_q[63:62]};
  assign sq_trial = {1'b0, acc_q, 2'b01};
  assign dv_rem   = {rem_q[33:0], x_q[63]};
  assign dv_den   = {3'd0, den_q};

  always_comb begin
    case (op_q)
      rbe_pkg::OP_SQRT: begin
        x_n = {x_q[61:0], 2'b00};
        if (sq_rem >= sq_trial) begin
          rem_n = sq_rem - sq_trial;
          acc_n = {acc_q[30:0], 1'b1};
        end else begin
          rem_n = sq_rem;
          acc_n = {acc_q[30:0], 1'b0};
        end
      end
      rbe_pkg::OP_DIV: begin
        x_n = {x_q[62:0], 1'b0};
        if (dv_rem >= dv_den) begin
          rem_n = dv_rem - dv_den;
          acc_n = {acc_q[30:0], 1'b1};
        end else begin
          rem_n = dv_rem;
          acc_n = {acc_q[30:0], 1'b0};
        end
      end
      default: begin
        x_n   = x_q;
        rem_n = rem_q;
        acc_n = acc_q;
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = (req_i.op == rbe_pkg::OP_SQRT) ? 6'd31 : 6'd63;
    end else if (busy_q) begin
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      x_q   <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      acc_q <= '0;
    end else if (busy_q) begin
      x_q   <= x_n;
      rem_q <= rem_n;
      acc_q <= acc_n;
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

// File: rtl/core/rigid_body_euler_step.sv
// ----------------------------------------------------------------------------
// rigid_body_euler_step
// 2-D rigid body stepped by semi-implicit Euler integration in Q16.16.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i/in_stall_o with force_x_i, force_y_i,
// on_ground_i and time_step_i. One request is one simulation tick.
// Output channel: out_valid_o/out_stall_i with new position and velocity,
// exactly one result per request.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (gravity x/y, friction, body mass, inverse mass). The user must write
// only while the block is idle; the block itself does not enforce this.
// One request is worked through by a sequencer around one 48x18 multiplier
// and one shared square-root/divide unit.
// The block takes one request at a time: in_stall_o is high from accept
// until the result is in the output register. A finished result waits in
// the output register while out_stall_i is high; the next request can
// already be accepted and worked on meanwhile.
// Reset clears velocity and position to zero and loads default registers.
// ----------------------------------------------------------------------------
module rigid_body_euler_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] force_x_i,
  input  logic signed [31:0] force_y_i,
  input  logic               on_ground_i,
  input  logic [15:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i
);

  rbe_pkg::rbe_state_e state_q, state_d;
  logic [1:0]          ph_q, ph_d;

  logic signed [31:0] grav_x_q, grav_y_q;
  logic [30:0]        fric_q, mass_q, inv_mass_q;

  logic signed [31:0] fx_q, fy_q;
  logic               gnd_q;
  logic [15:0]        dt_q;
  logic               load_in;

  logic signed [31:0] vel_x_q, vel_x_d, vel_y_q, vel_y_d;
  logic signed [31:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;

  logic signed [65:0] tmp_q, tmp_d;
  logic signed [31:0] ux_q, ux_d, uy_q, uy_d;
  logic [31:0]        m_q, m_d;
  logic [32:0]        f_q, f_d;

  logic signed [47:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [17:0] mul_bs;
  logic signed [65:0] mres;
  logic signed [65:0] part_q, prod_q;
  logic signed [65:0] sh16, sh30;

  rbe_pkg::rbe_iter_req_t it_req;
  logic [63:0]        it_num;
  logic [31:0]        it_den;
  logic               it_done;
  logic [31:0]        it_res;

  logic               out_valid_q, out_valid_d, load_out;
  logic signed [31:0] out_px_q, out_py_q, out_vx_q, out_vy_q;

  logic [32:0]        damp_r;
  logic [31:0]        gx_mag, gy_mag, vx_mag, vy_mag;
  logic [47:0]        dt_a;

  assign gx_mag = rbe_pkg::mag32(grav_x_q);
  assign gy_mag = rbe_pkg::mag32(grav_y_q);
  assign vx_mag = rbe_pkg::mag32(vel_x_q);
  assign vy_mag = rbe_pkg::mag32(vel_y_q);
  assign dt_a   = {32'd0, dt_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_x_q   <= rbe_pkg::GRAVITY_X_RST;
      grav_y_q   <= rbe_pkg::GRAVITY_Y_RST;
      fric_q     <= rbe_pkg::FRICTION_RST;
      mass_q     <= rbe_pkg::BODY_MASS_RST;
      inv_mass_q <= rbe_pkg::INV_MASS_RST;
    end else if (cfg_we_i) begin
      case (rbe_pkg::rbe_reg_e'(cfg_idx_i))
        rbe_pkg::REG_GRAVITY_X: grav_x_q   <= cfg_wdata_i;
        rbe_pkg::REG_GRAVITY_Y: grav_y_q   <= cfg_wdata_i;
        rbe_pkg::REG_FRICTION:  fric_q     <= cfg_wdata_i[30:0];
        rbe_pkg::REG_BODY_MASS: mass_q     <= cfg_wdata_i[30:0];
        rbe_pkg::REG_INV_MASS:  inv_mass_q <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      rbe_pkg::S_AX: begin
        mul_a = rbe_pkg::sx48(fx_q);
        mul_b = {3'd0, inv_mass_q};
      end
      rbe_pkg::S_AY: begin
        mul_a = rbe_pkg::sx48(fy_q);
        mul_b = {3'd0, inv_mass_q};
      end
      rbe_pkg::S_VX, rbe_pkg::S_VY: begin
        mul_a = rbe_pkg::sx48(tmp_q[31:0]);
        mul_b = {18'd0, dt_q};
      end
      rbe_pkg::S_GX2: begin
        mul_a = {16'd0, gx_mag};
        mul_b = {2'd0, gx_mag};
      end
      rbe_pkg::S_GY2: begin
        mul_a = {16'd0, gy_mag};
        mul_b = {2'd0, gy_mag};
      end
      rbe_pkg::S_D1: begin
        mul_a = rbe_pkg::sx48(vel_x_q);
        mul_b = {{2{ux_q[31]}}, ux_q};
      end
      rbe_pkg::S_D2: begin
        mul_a = rbe_pkg::sx48(vel_y_q);
        mul_b = {{2{uy_q[31]}}, uy_q};
      end
      rbe_pkg::S_RX: begin
        mul_a = rbe_pkg::sx48(ux_q);
        mul_b = tmp_q[33:0];
      end
      rbe_pkg::S_RY: begin
        mul_a = rbe_pkg::sx48(uy_q);
        mul_b = tmp_q[33:0];
      end
      rbe_pkg::S_GVX: begin
        mul_a = rbe_pkg::sx48(grav_x_q);
        mul_b = {18'd0, dt_q};
      end
      rbe_pkg::S_GVY: begin
        mul_a = rbe_pkg::sx48(grav_y_q);
        mul_b = {18'd0, dt_q};
      end
      rbe_pkg::S_F1: begin
        mul_a = {17'd0, fric_q};
        mul_b = {3'd0, mass_q};
      end
      rbe_pkg::S_F2: begin
        mul_a = tmp_q[47:0];
        mul_b = {18'd0, dt_q};
      end
      rbe_pkg::S_V2X: begin
        mul_a = {16'd0, vx_mag};
        mul_b = {2'd0, vx_mag};
      end
      rbe_pkg::S_V2Y: begin
        mul_a = {16'd0, vy_mag};
        mul_b = {2'd0, vy_mag};
      end
      rbe_pkg::S_DX1: begin
        mul_a = {16'd0, vx_mag};
        mul_b = {1'b0, f_q};
      end
      rbe_pkg::S_DY1: begin
        mul_a = {16'd0, vy_mag};
        mul_b = {1'b0, f_q};
      end
      rbe_pkg::S_PX: begin
        mul_a = rbe_pkg::sx48(vel_x_q);
        mul_b = {18'd0, dt_q};
      end
      rbe_pkg::S_PY: begin
        mul_a = rbe_pkg::sx48(vel_y_q);
        mul_b = {18'd0, dt_q};
      end
      default: begin
        mul_a = dt_a;
        mul_b = '0;
      end
    endcase
  end

  assign mul_bs = (ph_q == 2'd0) ? {1'b0, mul_b[16:0]} : {mul_b[33], mul_b[33:17]};
  assign mres   = mul_a * mul_bs;
  assign sh16   = prod_q >>> 16;
  assign sh30   = prod_q >>> 30;

  always_ff @(posedge clk_i) begin
    if (ph_q == 2'd0) begin
      part_q <= mres;
    end else if (ph_q == 2'd1) begin
      prod_q <= part_q + (mres <<< 17);
    end
  end

  // shared root / divide unit requests
  always_comb begin
    it_req.start = 1'b0;
    it_req.op    = rbe_pkg::OP_SQRT;
    it_num       = tmp_q[63:0];
    it_den       = m_q;
    case (state_q)
      rbe_pkg::S_GLEN, rbe_pkg::S_VLEN: begin
        it_req.start = (ph_q == 2'd0);
      end
      rbe_pkg::S_UX: begin
        it_req.start = (ph_q == 2'd0);
        it_req.op    = rbe_pkg::OP_DIV;
        it_num       = {2'd0, gx_mag, 30'd0};
      end
      rbe_pkg::S_UY: begin
        it_req.start = (ph_q == 2'd0);
        it_req.op    = rbe_pkg::OP_DIV;
        it_num       = {2'd0, gy_mag, 30'd0};
      end
      rbe_pkg::S_DX2, rbe_pkg::S_DY2: begin
        it_req.start = (ph_q == 2'd0);
        it_req.op    = rbe_pkg::OP_DIV;
      end
      default: ;
    endcase
  end

  rbe_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (it_req),
    .num_i  (it_num),
    .den_i  (it_den),
    .done_o (it_done),
    .res_o  (it_res)
  );

  assign damp_r = (state_q == rbe_pkg::S_DX2) ? ({1'b0, vx_mag} - {1'b0, it_res})
                                              : ({1'b0, vy_mag} - {1'b0, it_res});
  assign load_out = (state_q == rbe_pkg::S_DONE) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    load_in     = 1'b0;
    vel_x_d     = vel_x_q;
    vel_y_d     = vel_y_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    tmp_d       = tmp_q;
    ux_d        = ux_q;
    uy_d        = uy_q;
    m_d         = m_q;
    f_d         = f_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      rbe_pkg::S_IDLE, rbe_pkg::S_DONE: ph_d = 2'd0;
      rbe_pkg::S_GLEN, rbe_pkg::S_VLEN, rbe_pkg::S_UX, rbe_pkg::S_UY,
      rbe_pkg::S_DX2, rbe_pkg::S_DY2: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else if (it_done) begin
          ph_d = 2'd0;
        end
      end
      rbe_pkg::S_FCHK: ph_d = 2'd0;
      default: ph_d = (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
    endcase

    case (state_q)
      rbe_pkg::S_IDLE: begin
        if (in_valid_i) begin
          load_in = 1'b1;
          state_d = rbe_pkg::S_AX;
        end
      end
      rbe_pkg::S_AX: begin
        if (ph_q == 2'd2) begin
          tmp_d   = rbe_pkg::sx66(rbe_pkg::sat32(sh16));
          state_d = rbe_pkg::S_VX;
        end
      end
      rbe_pkg::S_VX: begin
        if (ph_q == 2'd2) begin
          vel_x_d = rbe_pkg::sat32(rbe_pkg::sx66(vel_x_q) + sh16);
          state_d = rbe_pkg::S_AY;
        end
      end
      rbe_pkg::S_AY: begin
        if (ph_q == 2'd2) begin
          tmp_d   = rbe_pkg::sx66(rbe_pkg::sat32(sh16));
          state_d = rbe_pkg::S_VY;
        end
      end
      rbe_pkg::S_VY: begin
        if (ph_q == 2'd2) begin
          vel_y_d = rbe_pkg::sat32(rbe_pkg::sx66(vel_y_q) + sh16);
          state_d = gnd_q ? rbe_pkg::S_GX2 : rbe_pkg::S_GVX;
        end
      end
      rbe_pkg::S_GX2: begin
        if (ph_q == 2'd2) begin
          tmp_d   = prod_q;
          state_d = rbe_pkg::S_GY2;
        end
      end
      rbe_pkg::S_GY2: begin
        if (ph_q == 2'd2) begin
          tmp_d   = tmp_q + prod_q;
          state_d = rbe_pkg::S_GLEN;
        end
      end
      rbe_pkg::S_GLEN: begin
        if (ph_q == 2'd1 && it_done) begin
          m_d     = it_res;
          state_d = (it_res == 32'd0) ? rbe_pkg::S_FCHK : rbe_pkg::S_UX;
        end
      end
      rbe_pkg::S_UX: begin
        if (ph_q == 2'd1 && it_done) begin
          ux_d    = grav_x_q[31] ? (~it_res + 32'd1) : it_res;
          state_d = rbe_pkg::S_UY;
        end
      end
      rbe_pkg::S_UY: begin
        if (ph_q == 2'd1 && it_done) begin
          uy_d    = grav_y_q[31] ? (~it_res + 32'd1) : it_res;
          state_d = rbe_pkg::S_D1;
        end
      end
      rbe_pkg::S_D1: begin
        if (ph_q == 2'd2) begin
          tmp_d   = prod_q;
          state_d = rbe_pkg::S_D2;
        end
      end
      rbe_pkg::S_D2: begin
        if (ph_q == 2'd2) begin
          tmp_d   = (tmp_q + prod_q) >>> 30;
          state_d = rbe_pkg::S_RX;
        end
      end
      rbe_pkg::S_RX: begin
        if (ph_q == 2'd2) begin
          vel_x_d = rbe_pkg::sat32(rbe_pkg::sx66(vel_x_q) - sh30);
          state_d = rbe_pkg::S_RY;
        end
      end
      rbe_pkg::S_RY: begin
        if (ph_q == 2'd2) begin
          vel_y_d = rbe_pkg::sat32(rbe_pkg::sx66(vel_y_q) - sh30);
          state_d = rbe_pkg::S_FCHK;
        end
      end
      rbe_pkg::S_GVX: begin
        if (ph_q == 2'd2) begin
          vel_x_d = rbe_pkg::sat32(rbe_pkg::sx66(vel_x_q) + sh16);
          state_d = rbe_pkg::S_GVY;
        end
      end
      rbe_pkg::S_GVY: begin
        if (ph_q == 2'd2) begin
          vel_y_d = rbe_pkg::sat32(rbe_pkg::sx66(vel_y_q) + sh16);
          state_d = rbe_pkg::S_FCHK;
        end
      end
      rbe_pkg::S_FCHK: begin
        state_d = (vel_x_q == 32'sd0 && vel_y_q == 32'sd0) ? rbe_pkg::S_PX
                                                           : rbe_pkg::S_F1;
      end
      rbe_pkg::S_F1: begin
        if (ph_q == 2'd2) begin
          tmp_d   = sh16;
          state_d = rbe_pkg::S_F2;
        end
      end
      rbe_pkg::S_F2: begin
        if (ph_q == 2'd2) begin
          f_d     = (sh16[65:32] != '0) ? {1'b1, 32'd0} : sh16[32:0];
          state_d = rbe_pkg::S_V2X;
        end
      end
      rbe_pkg::S_V2X: begin
        if (ph_q == 2'd2) begin
          tmp_d   = prod_q;
          state_d = rbe_pkg::S_V2Y;
        end
      end
      rbe_pkg::S_V2Y: begin
        if (ph_q == 2'd2) begin
          tmp_d   = tmp_q + prod_q;
          state_d = rbe_pkg::S_VLEN;
        end
      end
      rbe_pkg::S_VLEN: begin
        if (ph_q == 2'd1 && it_done) begin
          m_d = it_res;
          if ({1'b0, it_res} < f_q) begin
            vel_x_d = '0;
            vel_y_d = '0;
            state_d = rbe_pkg::S_PX;
          end else if (f_q == 33'd0) begin
            state_d = rbe_pkg::S_PX;
          end else begin
            state_d = rbe_pkg::S_DX1;
          end
        end
      end
      rbe_pkg::S_DX1: begin
        if (ph_q == 2'd2) begin
          tmp_d   = prod_q;
          state_d = rbe_pkg::S_DX2;
        end
      end
      rbe_pkg::S_DX2: begin
        if (ph_q == 2'd1 && it_done) begin
          vel_x_d = vel_x_q[31] ? 32'(~damp_r + 33'd1) : damp_r[31:0];
          state_d = rbe_pkg::S_DY1;
        end
      end
      rbe_pkg::S_DY1: begin
        if (ph_q == 2'd2) begin
          tmp_d   = prod_q;
          state_d = rbe_pkg::S_DY2;
        end
      end
      rbe_pkg::S_DY2: begin
        if (ph_q == 2'd1 && it_done) begin
          vel_y_d = vel_y_q[31] ? 32'(~damp_r + 33'd1) : damp_r[31:0];
          state_d = rbe_pkg::S_PX;
        end
      end
      rbe_pkg::S_PX: begin
        if (ph_q == 2'd2) begin
          pos_x_d = rbe_pkg::sat32(rbe_pkg::sx66(pos_x_q) + sh16);
          state_d = rbe_pkg::S_PY;
        end
      end
      rbe_pkg::S_PY: begin
        if (ph_q == 2'd2) begin
          pos_y_d = rbe_pkg::sat32(rbe_pkg::sx66(pos_y_q) + sh16);
          state_d = rbe_pkg::S_DONE;
        end
      end
      rbe_pkg::S_DONE: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = rbe_pkg::S_IDLE;
        end
      end
      default: state_d = rbe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbe_pkg::S_IDLE;
      ph_q        <= '0;
      out_valid_q <= 1'b0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
      vel_x_q     <= vel_x_d;
      vel_y_q     <= vel_y_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q <= tmp_d;
    ux_q  <= ux_d;
    uy_q  <= uy_d;
    m_q   <= m_d;
    f_q   <= f_d;
    if (load_in) begin
      fx_q  <= force_x_i;
      fy_q  <= force_y_i;
      gnd_q <= on_ground_i;
      dt_q  <= time_step_i;
    end
    if (load_out) begin
      out_px_q <= pos_x_q;
      out_py_q <= pos_y_q;
      out_vx_q <= vel_x_q;
      out_vy_q <= vel_y_q;
    end
  end

  assign in_stall_o  = (state_q != rbe_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_px_q;
  assign pos_y_o     = out_py_q;
  assign vel_x_o     = out_vx_q;
  assign vel_y_o     = out_vy_q;

endmodule
